// ===== hdl/ipiwk_pkg.sv =====
// ipiwk_pkg: shared constants, sequencer states and wake helper functions
// for the ipi wake interrupt controller; no dependencies
package ipiwk_pkg;

	localparam int THREADS_DEF     = 6;
	localparam int STORE_BYTES_DEF = 32768;
	localparam int BLOCK_BYTES_DEF = 4096;

	localparam logic [7:0]  ID_MASK     = 8'h3f;
	localparam logic [7:0]  BOOT_VECTOR = 8'h78;
	localparam logic [63:0] FLIP_BIT    = 64'h2000;
	localparam logic [15:0] FLIP_ADDR   = 16'h6020;
	localparam logic [7:0]  IPI_OFF     = 8'h10;
	localparam logic [7:0]  WAKE_OFF    = 8'hf0;
	localparam logic [2:0]  TC_RESET    = 3'd6;
	localparam logic [3:0]  ID_BYTE     = 4'd7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_FLIP,
		ST_WR,
		ST_IPI,
		ST_FIN
	} seq_state_t;

	function automatic logic size_enc(input logic [3:0] size);
		return (size inside {4'd1, 4'd2, 4'd4, 4'd8});
	endfunction

	function automatic logic [7:0] wake_one(input logic [2:0] t, input logic [3:0] live,
		input logic halted);
		logic [7:0] m;
		m = 8'd0;
		if ({1'b0, t} < live && (t != 3'd0 || halted))
			m = 8'd1 << t;
		return m;
	endfunction

	function automatic logic [7:0] wake_pair(input logic [2:0] t, input logic [3:0] live,
		input logic halted);
		logic [7:0] m;
		logic [3:0] n;
		n = {1'b0, t} + 4'd1;
		m = wake_one(t, live, halted);
		if (!t[0] && n < live)
			m = m | wake_one(n[2:0], live, halted);
		return m;
	endfunction

endpackage

// ===== hdl/ipiwk_store.sv =====
// ipiwk_store: byte-wide register store, one write and one registered read port,
// with a clearing pass after reset that loads the per-thread id words; uses ipiwk_pkg
module ipiwk_store import ipiwk_pkg::*; #(
	parameter int THREADS     = THREADS_DEF,
	parameter int STORE_BYTES = STORE_BYTES_DEF,
	parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
	localparam int AW = $clog2(STORE_BYTES)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata,
	output logic          busy
);

	localparam int BW = $clog2(BLOCK_BYTES);

	logic [7:0]    mem [STORE_BYTES];
	logic [AW:0]   clr_q;
	logic [AW-1:0] wa;
	logic [7:0]    wd;
	logic          wen;
	logic [AW-1:0] blk;

	assign busy = !clr_q[AW];
	assign blk  = clr_q[AW-1:0] >> BW;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (busy) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_comb begin
		if (busy) begin
			wen = 1'b1;
			wa  = clr_q[AW-1:0];
			wd  = 8'd0;
			if (clr_q[BW-1:0] == BW'(ID_BYTE) && blk < AW'(THREADS))
				wd = 8'd1 << blk[2:0];
		end else begin
			wen = we;
			wa  = waddr;
			wd  = wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (wen)
			mem[wa] <= wd;
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/ipi_wake_interrupt_controller.sv =====
// ipi_wake_interrupt_controller: top level, access sequencer and ipi/wake logic
// around the byte store; uses ipiwk_pkg and ipiwk_store
//
// Bus accesses of 1, 2, 4 or 8 bytes reach a big-endian byte store one byte per
// cycle through a store with one write and one registered read port, and the
// sequencer handles one access at a time. A read at the flip register also
// writes the flipped value back, and an ipi write then reads the id words of
// the threads. After reset the store is loaded by a clearing pass before the
// first transfer is taken. A finished result waits in an output register while
// the next access is already accepted.
module ipi_wake_interrupt_controller import ipiwk_pkg::*; #(
	parameter int THREADS     = THREADS_DEF,
	parameter int STORE_BYTES = STORE_BYTES_DEF,
	parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [15:0] offset,
	input  logic [3:0]  access_size,
	input  logic [63:0] write_data,
	input  logic        boot_thread_halted,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] read_data,
	output logic [5:0]  reset_pulse_mask,
	output logic [7:0]  online_mask
);

	localparam int AW = $clog2(STORE_BYTES);
	localparam int BW = $clog2(BLOCK_BYTES);
	localparam logic [16:0] THR_END = 17'(THREADS * BLOCK_BYTES);

	seq_state_t state_q, state_d;

	logic [2:0]  tc_q;
	logic        kind_q, halted_q, toggle_q;
	logic [15:0] off_q;
	logic [3:0]  size_q, cnt_q;
	logic [63:0] data_q, acc_q, wbuf_q;
	logic [7:0]  pulse_q, online_q;
	logic        iss_s1, inr_s1;
	logic [2:0]  tid_s1;
	logic        out_valid_q;
	logic [63:0] rd_out_q;
	logic [5:0]  pm_out_q;
	logic [7:0]  om_out_q;

	logic          mem_we, busy;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [7:0]    mem_rdata, mem_wdata;
	logic [16:0]   addr;
	logic          in_rng;
	logic [3:0]  live;
	logic [63:0] acc_mod;
	logic [7:0]  id, ipi_m, wr_m;
	logic [2:0]  blk_t;
	logic        accept, out_free, last_wr;

	ipiwk_store #(
		.THREADS(THREADS), .STORE_BYTES(STORE_BYTES), .BLOCK_BYTES(BLOCK_BYTES)
	) u_store (
		.clk(clk), .arst_n(arst_n), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.raddr(mem_raddr), .rdata(mem_rdata), .busy(busy)
	);

	assign in_ready  = (state_q == ST_IDLE) && !busy;
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign read_data = rd_out_q;
	assign reset_pulse_mask = pm_out_q;
	assign online_mask      = om_out_q;

	assign live    = ({1'b0, tc_q} < 4'(THREADS)) ? {1'b0, tc_q} : 4'(THREADS);
	assign addr    = {1'b0, off_q} + {13'd0, cnt_q};
	assign in_rng  = addr < 17'(STORE_BYTES);
	assign last_wr = (cnt_q == size_q - 4'd1);
	assign blk_t   = 3'(off_q >> BW);
	assign acc_mod = toggle_q ? (acc_q | FLIP_BIT) : (acc_q & ~FLIP_BIT);

	always_comb begin
		id = mem_rdata & ID_MASK;
		if (id == 8'd0)
			id = 8'd1 << tid_s1;
		ipi_m = 8'd0;
		if (iss_s1 && (data_q[23:16] & id) != 8'd0)
			ipi_m = wake_pair(tid_s1, live, halted_q);
		if (cnt_q == 4'(THREADS) && data_q[7:0] == BOOT_VECTOR && live > 4'd1)
			ipi_m = ipi_m | wake_one(3'd1, live, halted_q);
	end

	always_comb begin
		wr_m = 8'd0;
		if ({1'b0, off_q} < THR_END && off_q[BW-1:0] == BW'(WAKE_OFF) && data_q != 64'd0)
			wr_m = wake_pair(blk_t, live, halted_q);
	end

	always_comb begin
		mem_we    = (state_q == ST_WR) && in_rng;
		mem_waddr = addr[AW-1:0];
		mem_wdata = wbuf_q[63:56];
		mem_raddr = addr[AW-1:0];
		if (state_q == ST_IPI)
			mem_raddr = AW'({cnt_q[2:0], BW'(ID_BYTE)});
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (!(access_size inside {[4'd1:4'd8]}))
						state_d = ST_FIN;
					else if (kind)
						state_d = ST_WR;
					else if (size_enc(access_size))
						state_d = ST_RD;
					else if (offset == FLIP_ADDR)
						state_d = ST_FLIP;
					else
						state_d = ST_FIN;
				end
			end
			ST_RD: begin
				if (cnt_q == size_q)
					state_d = (off_q == FLIP_ADDR) ? ST_FLIP : ST_FIN;
			end
			ST_FLIP: state_d = ST_WR;
			ST_WR: begin
				if (last_wr) begin
					if (kind_q && {1'b0, off_q} < THR_END && off_q[BW-1:0] == BW'(IPI_OFF))
						state_d = ST_IPI;
					else
						state_d = ST_FIN;
				end
			end
			ST_IPI: begin
				if (cnt_q == 4'(THREADS))
					state_d = ST_FIN;
			end
			ST_FIN: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tc_q        <= TC_RESET;
			toggle_q    <= 1'b0;
			online_q    <= 8'd0;
			out_valid_q <= 1'b0;
			iss_s1      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we)
				tc_q <= cfg_wdata;
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			iss_s1 <= 1'b0;
			case (state_q)
				ST_RD: begin
					iss_s1 <= cnt_q < size_q;
				end
				ST_FLIP: begin
					toggle_q <= !toggle_q;
				end
				ST_IPI: begin
					iss_s1 <= cnt_q < 4'(THREADS);
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						online_q    <= online_q | pulse_q;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		inr_s1 <= in_rng;
		tid_s1 <= cnt_q[2:0];
		case (state_q)
			ST_IDLE: begin
				kind_q   <= kind;
				off_q    <= offset;
				size_q   <= access_size;
				data_q   <= write_data;
				halted_q <= boot_thread_halted;
				acc_q    <= 64'd0;
				pulse_q  <= 8'd0;
				cnt_q    <= 4'd0;
				wbuf_q   <= size_enc(access_size) ?
					(write_data << {4'd8 - access_size, 3'b000}) : 64'd0;
			end
			ST_RD: begin
				cnt_q <= (cnt_q == size_q) ? 4'd0 : cnt_q + 4'd1;
				if (iss_s1)
					acc_q <= {acc_q[55:0], inr_s1 ? mem_rdata : 8'd0};
			end
			ST_FLIP: begin
				acc_q  <= acc_mod;
				cnt_q  <= 4'd0;
				wbuf_q <= size_enc(size_q) ? (acc_mod << {4'd8 - size_q, 3'b000}) : 64'd0;
			end
			ST_WR: begin
				wbuf_q <= {wbuf_q[55:0], 8'd0};
				cnt_q  <= last_wr ? 4'd0 : cnt_q + 4'd1;
				if (last_wr && kind_q)
					pulse_q <= pulse_q | wr_m;
			end
			ST_IPI: begin
				cnt_q   <= cnt_q + 4'd1;
				pulse_q <= pulse_q | ipi_m;
			end
			ST_FIN: begin
				if (out_free) begin
					rd_out_q <= kind_q ? 64'd0 : acc_q;
					pm_out_q <= pulse_q[5:0];
					om_out_q <= online_q | pulse_q;
				end
			end
			default: ;
		endcase
	end

endmodule
